// ===== hdl/dcc_pkg.sv =====
// shared types, class codes and colors for the dominant color classifier
`timescale 1ns / 1ps

package dcc_pkg;

  localparam int CHAN_W         = 8;
  localparam int NUM_CLASSES    = 6;
  localparam int CLASS_W        = 3;
  localparam int RGB_W          = 24;
  localparam int COUNT_BITS_DEF = 16;

  localparam logic [CLASS_W-1:0] CLS_RED     = 3'd0;
  localparam logic [CLASS_W-1:0] CLS_GREEN   = 3'd1;
  localparam logic [CLASS_W-1:0] CLS_BLUE    = 3'd2;
  localparam logic [CLASS_W-1:0] CLS_YELLOW  = 3'd3;
  localparam logic [CLASS_W-1:0] CLS_MAGENTA = 3'd4;
  localparam logic [CLASS_W-1:0] CLS_CYAN    = 3'd5;
  localparam logic [CLASS_W-1:0] CLS_NONE    = 3'd6;

  localparam logic [CHAN_W-1:0] CHAN_FULL = 8'hFF;
  localparam logic [CHAN_W-1:0] CHAN_ZERO = 8'h00;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
    logic              last_pixel;
  } pix_t;

  typedef struct packed {
    logic [CLASS_W-1:0] class_code;
    logic [RGB_W-1:0]   dominant_rgb;
  } res_t;

  typedef struct packed {
    logic update;
    logic close;
    logic snap_take;
  } cnt_ctrl_t;

  function automatic logic [RGB_W-1:0] class_rgb(input logic [CLASS_W-1:0] code);
    logic [RGB_W-1:0] rgb;
    unique case (code)
      CLS_RED:     rgb = 24'hFF0000;
      CLS_GREEN:   rgb = 24'h00FF00;
      CLS_BLUE:    rgb = 24'h0000FF;
      CLS_YELLOW:  rgb = 24'hFFFF00;
      CLS_MAGENTA: rgb = 24'hFF00FF;
      CLS_CYAN:    rgb = 24'h00FFFF;
      default:     rgb = '0;
    endcase
    return rgb;
  endfunction

endpackage

// ===== hdl/dominant_color_classifier_top.sv =====
// top level of the dominant color classifier
`timescale 1ns / 1ps

// pixels arrive on the in_ channel as requests (valid/ready), one per cycle when
// in_ready is high, each with red, green, blue, alpha and a last_pixel flag
// alpha zero or the magenta key pixel is not counted
// cfg_ writes set the 8-bit intensity threshold; write only while idle
// each counted pixel bumps any of six saturating hue counters
// on the last pixel the out_ channel delivers one request: the class code
// of the largest count (lowest code on a tie, none when all zero) and its color
// after the last pixel is accepted, the result passes through the input register,
//   the counter update and snapshot, and the selection into the result register
// throughput: one pixel per cycle while in_ready is high, set by the counter update
// a result waiting for out_ready does not block pixels; only a second
//   last pixel stalls in_ready while both snapshot and result are occupied
// reset clears counters, pipeline valids and the threshold (to zero)
module dominant_color_classifier_top #(
  parameter int COUNT_BITS = dcc_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  dcc_pkg::pix_t                 in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output dcc_pkg::res_t                 out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dcc_pkg::CHAN_W-1:0]    cfg_data
);
  import dcc_pkg::*;

  pix_t                                   pix_r;
  logic                                   pix_valid_r;
  logic [CHAN_W-1:0]                      thresh_r;
  logic [NUM_CLASSES-1:0]                 hits;
  logic                                   snap_valid;
  logic [NUM_CLASSES-1:0][COUNT_BITS-1:0] snap_counts;
  logic                                   out_free;
  logic                                   snap_free;
  logic                                   pix_proc;
  cnt_ctrl_t                              ctrl;

  assign out_free  = !out_valid || out_ready;
  assign snap_free = !snap_valid || out_free;
  assign pix_proc  = pix_valid_r && (!pix_r.last_pixel || snap_free);
  assign in_ready  = !pix_valid_r || pix_proc;
  assign cfg_ready = 1'b1;

  assign ctrl.update    = pix_proc;
  assign ctrl.close     = pix_proc && pix_r.last_pixel;
  assign ctrl.snap_take = snap_valid && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_valid_r <= 1'b0;
      thresh_r    <= '0;
    end else begin
      if (in_ready) begin
        pix_valid_r <= in_valid;
      end
      if (cfg_valid) begin
        thresh_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      pix_r <= in_data;
    end
  end

  dcc_match u_match (
    .pix    (pix_r),
    .thresh (thresh_r),
    .hits   (hits)
  );

  dcc_counters #(.COUNT_BITS(COUNT_BITS)) u_counters (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl        (ctrl),
    .hits        (hits),
    .snap_valid  (snap_valid),
    .snap_counts (snap_counts)
  );

  dcc_select #(.COUNT_BITS(COUNT_BITS)) u_select (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (ctrl.snap_take),
    .counts    (snap_counts),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_res   (out_data)
  );

endmodule

// ===== hdl/dcc_match.sv =====
// hue class match flags for one registered pixel
`timescale 1ns / 1ps

module dcc_match (
  input  dcc_pkg::pix_t                    pix,
  input  logic [dcc_pkg::CHAN_W-1:0]       thresh,
  output logic [dcc_pkg::NUM_CLASSES-1:0]  hits
);
  import dcc_pkg::*;

  logic [CHAN_W:0] d_rg, d_rb, d_gr, d_gb, d_bg, d_br;
  logic            l_rg, l_rb, l_gr, l_gb, l_bg, l_br;
  logic            keyed;
  logic            skip;

  function automatic logic leads(input logic [CHAN_W:0] d, input logic [CHAN_W-1:0] t);
    return !d[CHAN_W] && (d[CHAN_W-1:0] != '0) && (d[CHAN_W-1:0] >= t);
  endfunction

  assign d_rg = {1'b0, pix.red}   - {1'b0, pix.green};
  assign d_rb = {1'b0, pix.red}   - {1'b0, pix.blue};
  assign d_gr = {1'b0, pix.green} - {1'b0, pix.red};
  assign d_gb = {1'b0, pix.green} - {1'b0, pix.blue};
  assign d_bg = {1'b0, pix.blue}  - {1'b0, pix.green};
  assign d_br = {1'b0, pix.blue}  - {1'b0, pix.red};

  assign l_rg = leads(d_rg, thresh);
  assign l_rb = leads(d_rb, thresh);
  assign l_gr = leads(d_gr, thresh);
  assign l_gb = leads(d_gb, thresh);
  assign l_bg = leads(d_bg, thresh);
  assign l_br = leads(d_br, thresh);

  assign keyed = (pix.red == CHAN_FULL) && (pix.green == CHAN_ZERO) && (pix.blue == CHAN_FULL);
  assign skip  = keyed || (pix.alpha == CHAN_ZERO);

  always_comb begin
    hits = '0;
    if (!skip) begin
      hits[CLS_RED]     = l_rg && l_rb;
      hits[CLS_GREEN]   = l_gr && l_gb;
      hits[CLS_BLUE]    = l_bg && l_br;
      hits[CLS_YELLOW]  = l_rb && l_gb;
      hits[CLS_MAGENTA] = l_rg && l_bg;
      hits[CLS_CYAN]    = l_gr && l_br;
    end
  end

endmodule

// ===== hdl/dcc_counters.sv =====
// saturating class counters and the end-of-image count snapshot
`timescale 1ns / 1ps

module dcc_counters #(
  parameter int COUNT_BITS = dcc_pkg::COUNT_BITS_DEF
) (
  input  logic                                               clk,
  input  logic                                               rst_n,
  input  dcc_pkg::cnt_ctrl_t                                 ctrl,
  input  logic [dcc_pkg::NUM_CLASSES-1:0]                    hits,
  output logic                                               snap_valid,
  output logic [dcc_pkg::NUM_CLASSES-1:0][COUNT_BITS-1:0]    snap_counts
);
  import dcc_pkg::*;

  logic [NUM_CLASSES-1:0][COUNT_BITS-1:0] counts_r, counts_nxt;
  logic [NUM_CLASSES-1:0][COUNT_BITS-1:0] snap_r;
  logic                                   snap_valid_r;

  // saturating increment of each matched class
  always_comb begin
    for (int k = 0; k < NUM_CLASSES; k++) begin
      if (hits[k] && (counts_r[k] != '1)) begin
        counts_nxt[k] = counts_r[k] + 1'b1;
      end else begin
        counts_nxt[k] = counts_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      counts_r     <= '0;
      snap_valid_r <= 1'b0;
    end else begin
      if (ctrl.close) begin
        counts_r <= '0;
      end else if (ctrl.update) begin
        counts_r <= counts_nxt;
      end
      if (ctrl.close) begin
        snap_valid_r <= 1'b1;
      end else if (ctrl.snap_take) begin
        snap_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.close) begin
      snap_r <= counts_nxt;
    end
  end

  assign snap_valid  = snap_valid_r;
  assign snap_counts = snap_r;

  a_clear_after_close: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.close |=> counts_r == '0)
    else $error("counters not cleared after last pixel");

  a_no_snap_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (snap_valid_r && !ctrl.snap_take) |-> !ctrl.close)
    else $error("pending snapshot overwritten");

  a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.update && !ctrl.close) |=> counts_r[0] >= $past(counts_r[0]))
    else $error("red counter decreased within an image");

endmodule

// ===== hdl/dcc_select.sv =====
// dominant class selection and result register
`timescale 1ns / 1ps

module dcc_select #(
  parameter int COUNT_BITS = dcc_pkg::COUNT_BITS_DEF
) (
  input  logic                                             clk,
  input  logic                                             rst_n,
  input  logic                                             load,
  input  logic [dcc_pkg::NUM_CLASSES-1:0][COUNT_BITS-1:0]  counts,
  input  logic                                             out_ready,
  output logic                                             out_valid,
  output dcc_pkg::res_t                                    out_res
);
  import dcc_pkg::*;

  logic [COUNT_BITS-1:0] c01, c23, c45, c03, cbest;
  logic [CLASS_W-1:0]    i01, i23, i45, i03, ibest;
  logic [CLASS_W-1:0]    code;
  logic                  out_valid_r;
  res_t                  res_r;

  // pairwise tree, the later class wins only on a strictly larger count
  always_comb begin
    if (counts[1] > counts[0]) begin
      c01 = counts[1]; i01 = CLS_GREEN;
    end else begin
      c01 = counts[0]; i01 = CLS_RED;
    end
    if (counts[3] > counts[2]) begin
      c23 = counts[3]; i23 = CLS_YELLOW;
    end else begin
      c23 = counts[2]; i23 = CLS_BLUE;
    end
    if (counts[5] > counts[4]) begin
      c45 = counts[5]; i45 = CLS_CYAN;
    end else begin
      c45 = counts[4]; i45 = CLS_MAGENTA;
    end
    if (c23 > c01) begin
      c03 = c23; i03 = i23;
    end else begin
      c03 = c01; i03 = i01;
    end
    if (c45 > c03) begin
      cbest = c45; ibest = i45;
    end else begin
      cbest = c03; ibest = i03;
    end
    code = (cbest == '0) ? CLS_NONE : ibest;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r.class_code   <= code;
      res_r.dominant_rgb <= class_rgb(code);
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  a_none_is_black: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.class_code == CLS_NONE) |-> res_r.dominant_rgb == '0)
    else $error("no-class result carries a color");

endmodule
